>>> src/npcm_pkg.sv
// Shared types and constants for the nearest palette colour mapper.
// No dependencies; imported by every module of the block.
package npcm_pkg;

  localparam int RGB_W  = 24;
  localparam int CHAN_W = 8;
  localparam int SIZE_W = 9;
  localparam int DIST_W = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_MAP  = 1'b1;

  localparam logic [1:0] OUTCOME_MAPPED      = 2'd0;
  localparam logic [1:0] OUTCOME_BACKGROUND  = 2'd1;
  localparam logic [1:0] OUTCOME_TRANSPARENT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SIZE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_COLOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_COLOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_COLOR  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] palette_size;
    logic              background_enable;
    logic [RGB_W-1:0]  background_color;
    logic              transparent_enable;
    logic [RGB_W-1:0]  transparent_color;
    logic [RGB_W-1:0]  replacement_color;
  } cfg_t;

  typedef struct packed {
    logic       pix_load;
    logic       pal_write;
    logic       scan_start;
    logic       scan_step;
    logic       res_load;
    logic [1:0] res_outcome;
  } dp_cmd_t;

  typedef struct packed {
    logic bg_hit;
    logic tr_hit;
    logic scan_last;
    logic pipe_busy;
  } dp_sts_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> src/npcm_cfg.sv
// Configuration register file for the palette mapper.
// Depends on npcm_pkg (cfg_t, register indexes).
module npcm_cfg import npcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RGB_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.palette_size       <= 9'd256;
      cfg_r.background_enable  <= 1'b0;
      cfg_r.background_color   <= '0;
      cfg_r.transparent_enable <= 1'b0;
      cfg_r.transparent_color  <= '0;
      cfg_r.replacement_color  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PALETTE_SIZE:       cfg_r.palette_size       <= cfg_data[SIZE_W-1:0];
        REG_BACKGROUND_ENABLE:  cfg_r.background_enable  <= cfg_data[0];
        REG_BACKGROUND_COLOR:   cfg_r.background_color   <= cfg_data;
        REG_TRANSPARENT_ENABLE: cfg_r.transparent_enable <= cfg_data[0];
        REG_TRANSPARENT_COLOR:  cfg_r.transparent_color  <= cfg_data;
        REG_REPLACEMENT_COLOR:  cfg_r.replacement_color  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/npcm_ctrl.sv
// Sequencing state machine: input transfer, classify, palette scan, result hand-off.
// Depends on npcm_pkg (state_t, dp_cmd_t, dp_sts_t, codes).
module npcm_ctrl import npcm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  logic    in_tuser,
  output logic    out_tvalid,
  input  logic    out_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] outcome_r, outcome_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      outcome_r   <= OUTCOME_MAPPED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      outcome_r   <= outcome_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    outcome_nxt   = outcome_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.res_outcome = outcome_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == CMD_MAP) begin
            cmd.pix_load = 1'b1;
            state_nxt    = ST_CLASSIFY;
          end else begin
            cmd.pal_write = 1'b1;
          end
        end
      end
      ST_CLASSIFY: begin
        if (sts.bg_hit) begin
          outcome_nxt = OUTCOME_BACKGROUND;
          state_nxt   = ST_FINISH;
        end else if (sts.tr_hit) begin
          outcome_nxt = OUTCOME_TRANSPARENT;
          state_nxt   = ST_FINISH;
        end else begin
          outcome_nxt    = OUTCOME_MAPPED;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> src/npcm_dp.sv
// Datapath: palette memory, scan counter, distance pipeline, best tracker, result register.
// Depends on npcm_pkg (cfg_t, dp_cmd_t, dp_sts_t, abs_diff).
module npcm_dp import npcm_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic [31:0] in_tdata,
  output logic [31:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SIZE_W-1:0] DEPTH_CNT = SIZE_W'(DEPTH);

  logic [RGB_W-1:0]  mem [DEPTH];
  logic [RGB_W-1:0]  in_rgb;
  logic [RGB_W-1:0]  pix_r;
  logic              wr_en;
  logic [IDX_W-1:0]  scan_addr_r;
  logic [IDX_W-1:0]  last_idx;
  logic [SIZE_W-1:0] sat_cnt, eff_cnt, eff_last;
  logic [RGB_W-1:0]  rd_data_r;
  logic              v1_r, v2_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r;
  logic [RGB_W-1:0]  col2_r;
  logic [15:0]       sq_r [3];
  logic [DIST_W-1:0] cand_dist;
  logic [DIST_W-1:0] best_dist_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [RGB_W-1:0]  best_col_r;
  logic [RGB_W-1:0]  res_col_r;
  logic [CHAN_W-1:0] res_idx_r;
  logic [1:0]        res_outcome_r;

  assign in_rgb = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
  assign wr_en  = cmd.pal_write && ({1'b0, in_tdata[7:0]} < DEPTH_CNT);

  // palette_size saturates at the store depth; zero still reads entry zero
  assign sat_cnt  = (cfg.palette_size > DEPTH_CNT) ? DEPTH_CNT : cfg.palette_size;
  assign eff_cnt  = (sat_cnt == '0) ? SIZE_W'(1) : sat_cnt;
  assign eff_last = eff_cnt - SIZE_W'(1);
  assign last_idx = eff_last[IDX_W-1:0];

  assign sts.bg_hit    = cfg.background_enable && (pix_r == cfg.background_color);
  assign sts.tr_hit    = cfg.transparent_enable && (pix_r == cfg.transparent_color);
  assign sts.scan_last = (scan_addr_r == last_idx);
  assign sts.pipe_busy = v1_r || v2_r;

  always_ff @(posedge clk) begin
    if (cmd.pix_load) begin
      pix_r <= in_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_tdata[IDX_W-1:0]] <= in_rgb;
    end
    rd_data_r <= mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_step) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      v1_r <= cmd.scan_step;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= scan_addr_r;
    idx2_r <= idx1_r;
    col2_r <= rd_data_r;
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= 16'(abs_diff(pix_r[c*CHAN_W +: CHAN_W], rd_data_r[c*CHAN_W +: CHAN_W]))
               * 16'(abs_diff(pix_r[c*CHAN_W +: CHAN_W], rd_data_r[c*CHAN_W +: CHAN_W]));
    end
  end

  assign cand_dist = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);

  // strict less-than keeps the first minimum
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      best_dist_r <= '1;
    end else if (v2_r && (cand_dist < best_dist_r)) begin
      best_dist_r <= cand_dist;
      best_idx_r  <= idx2_r;
      best_col_r  <= col2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_outcome_r <= cmd.res_outcome;
      case (cmd.res_outcome)
        OUTCOME_BACKGROUND: begin
          res_col_r <= pix_r;
          res_idx_r <= '0;
        end
        OUTCOME_TRANSPARENT: begin
          res_col_r <= cfg.replacement_color;
          res_idx_r <= '0;
        end
        default: begin
          res_col_r <= best_col_r;
          res_idx_r <= CHAN_W'(best_idx_r);
        end
      endcase
    end
  end

  assign out_tdata = {res_idx_r, res_col_r[7:0], res_col_r[15:8], res_col_r[23:16]};
  assign out_tuser = res_outcome_r;

endmodule

>>> src/nearest_palette_color_mapper_unit.sv
// Channel  Direction  tdata / tuser (lowest bit up)
// in_      slave      tdata: entry_index, red_in, green_in, blue_in; tuser: command
// out_     master     tdata: red_out, green_out, blue_out, chosen_index; tuser: outcome
// cfg_     slave      cfg_index (register number), cfg_data (value)
//
// A load writes its entry and stays idle. A map that hits background or transparent colour
// skips the palette scan; a palette map scans N entries, N being palette_size capped at
// PALETTE_DEPTH and at least 1, one entry per cycle through the single read port of the
// palette memory.
// One item is worked at a time; the next is taken while a result waits on out_.
// Synchronous active-low reset; the palette memory is not cleared.
module nearest_palette_color_mapper_unit import npcm_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // entry_index, red_in, green_in, blue_in
  input  logic                 in_tuser,   // command
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // red_out, green_out, blue_out, chosen_index
  output logic [1:0]           out_tuser,  // outcome
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RGB_W-1:0]     cfg_data
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  npcm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  npcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  npcm_dp #(
    .DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

>>> src/npcm_checker.sv
// Port-level checks for the palette mapper, bound to the top level.
// Depends on npcm_pkg (command and outcome codes).
module npcm_checker import npcm_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_unmapped_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != OUTCOME_MAPPED) |-> out_tdata[31:24] == 8'd0)
    else $error("non-zero index on unmapped result");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_LOAD) && !out_tvalid |=> !out_tvalid)
    else $error("load produced a result");

  a_map_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_MAP) |=> !in_tready)
    else $error("input taken while a map is in progress");

endmodule

bind nearest_palette_color_mapper_unit npcm_checker u_npcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/tb_nearest_palette_color_mapper_unit.sv
// Self-checking testbench for nearest_palette_color_mapper_unit: a directed table, a palette
// fill, then randomised phases, scored against fixed values or an in-bench nearest-colour predictor.
// Depends on npcm_pkg and the unit's RTL only.
module tb_nearest_palette_color_mapper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import npcm_pkg::*;

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] index;
    logic [1:0] outcome;
  } pixel_result_t;

  typedef enum bit [1:0] {ROW_CFG, ROW_ITEM, ROW_CHECKED} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    reg_sel;
    logic [RGB_W-1:0]        value;
    logic                    cmd;
    logic [7:0]              slot;
    pixel_result_t           want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [31:0]          in_tdata = '0;   // entry_index, red_in, green_in, blue_in
  logic                 in_tuser = 1'b0; // command
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;       // red_out, green_out, blue_out, chosen_index
  logic [1:0]           out_tuser;       // outcome
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RGB_W-1:0]     cfg_data = '0;

  bit [RGB_W-1:0]   palette_copy [DEPTH];
  logic [SIZE_W-1:0] cfg_size = 9'd256;
  logic             cfg_bg_en = 1'b0;
  logic [RGB_W-1:0] cfg_bg_colour = '0;
  logic             cfg_tr_en = 1'b0;
  logic [RGB_W-1:0] cfg_tr_colour = '0;
  logic [RGB_W-1:0] cfg_repl_colour = '0;

  pixel_result_t expected_pixels [$];
  plan_row_t     directed_plan [$];
  int            items_sent = 0;
  int            mismatches = 0;
  int            send_idle = 28;
  int            recv_idle = 85;
  int            hold_left = 0;
  bit            hold_done = 1'b0;

  nearest_palette_color_mapper_unit #(.PALETTE_DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned sq_gap(input logic [7:0] a, input logic [7:0] b);
    int diff;
    diff = int'(a) - int'(b);
    return unsigned'(diff * diff);
  endfunction

  function automatic pixel_result_t nearest_colour(input logic [RGB_W-1:0] pix);
    int unsigned span, best_k, best_d, d;
    bit [RGB_W-1:0] e;
    if (cfg_bg_en && pix == cfg_bg_colour) return {pix, 8'd0, OUTCOME_BACKGROUND};
    if (cfg_tr_en && pix == cfg_tr_colour)
      return {cfg_repl_colour, 8'd0, OUTCOME_TRANSPARENT};
    span = (cfg_size > DEPTH) ? DEPTH : cfg_size;
    best_k = 0;
    best_d = 32'hFFFF_FFFF;
    for (int unsigned k = 0; k < span; k++) begin
      e = palette_copy[k];
      d = sq_gap(pix[23:16], e[23:16]) + sq_gap(pix[15:8], e[15:8])
        + sq_gap(pix[7:0], e[7:0]);
      if (d < best_d) begin
        best_d = d;
        best_k = k;
      end
    end
    return {palette_copy[best_k], best_k[7:0], OUTCOME_MAPPED};
  endfunction

  function automatic logic [RGB_W-1:0] pick_colour();
    case ($urandom_range(0, 4))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return palette_copy[$urandom_range(0, DEPTH - 1)];
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [RGB_W-1:0] v);
    plan_row_t row;
    row = '{ROW_CFG, sel, v, CMD_LOAD, 8'd0, '0};
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void add_item(input logic cmd, input logic [7:0] slot,
                                   input logic [RGB_W-1:0] rgb);
    plan_row_t row;
    row = '{ROW_ITEM, REG_PALETTE_SIZE, rgb, cmd, slot, '0};
    directed_plan = {directed_plan, row};
  endfunction

  function automatic void add_checked(input logic [RGB_W-1:0] rgb, input logic [RGB_W-1:0] w_rgb,
                                      input logic [7:0] w_idx, input logic [1:0] w_outcome);
    plan_row_t row;
    row = '{ROW_CHECKED, REG_PALETTE_SIZE, rgb, CMD_MAP, 8'd0, {w_rgb, w_idx, w_outcome}};
    directed_plan = {directed_plan, row};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [RGB_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (sel)
      REG_PALETTE_SIZE:       cfg_size = value[SIZE_W-1:0];
      REG_BACKGROUND_ENABLE:  cfg_bg_en = value[0];
      REG_BACKGROUND_COLOR:   cfg_bg_colour = value;
      REG_TRANSPARENT_ENABLE: cfg_tr_en = value[0];
      REG_TRANSPARENT_COLOR:  cfg_tr_colour = value;
      REG_REPLACEMENT_COLOR:  cfg_repl_colour = value;
      default: ;
    endcase
  endtask

  // wait until every result is back, then let a trailing load finish
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [7:0] slot, input logic [RGB_W-1:0] rgb,
                           input bit typed, input pixel_result_t want);
    int gap;
    pixel_result_t exp_res;
    if (cfg_valid) cfg_valid <= 1'b0;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], slot};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_LOAD) begin
      palette_copy[slot] = rgb;
    end else begin
      exp_res = typed ? want : nearest_colour(rgb);
      expected_pixels = {expected_pixels, exp_res};
    end
    items_sent++;
    if (items_sent >= 1400) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (items_sent >= 700) begin
      send_idle = 85;
      recv_idle = 28;
    end
  endtask

  // receiver: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && items_sent >= 900) begin
      hold_left  <= 400;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[31:24], out_tuser};
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: rgb=%h%h%h idx=%0d outcome=%0d",
                   got.red, got.green, got.blue, got.index, got.outcome);
      end else begin
        want = expected_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.index !== want.index || got.outcome !== want.outcome) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected rgb=%h%h%h idx=%0d outcome=%0d, ",
                      "got rgb=%h%h%h idx=%0d outcome=%0d"},
                     want.red, want.green, want.blue, want.index, want.outcome,
                     got.red, got.green, got.blue, got.index, got.outcome);
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("tb_nearest_palette_color_mapper_unit: FAIL");
    $finish;
  end

  initial begin
    plan_row_t        row;
    logic [SIZE_W-1:0] size;
    logic [RGB_W-1:0] bgc, pix;
    int unsigned      span, pick, n, v;

    // directed: small palette, ties, zero size, background/transparent precedence
    add_cfg(REG_PALETTE_SIZE, 24'd4);
    add_item(CMD_LOAD, 8'd0, 24'h000000);
    add_item(CMD_LOAD, 8'd1, 24'hFFFFFF);
    add_item(CMD_LOAD, 8'd2, 24'hFF0000);
    add_item(CMD_LOAD, 8'd3, 24'hFF0000);
    add_checked(24'h000000, 24'h000000, 8'd0, OUTCOME_MAPPED);
    add_checked(24'hFFFFFF, 24'hFFFFFF, 8'd1, OUTCOME_MAPPED);
    add_checked(24'hFE0101, 24'hFF0000, 8'd2, OUTCOME_MAPPED);
    add_item(CMD_MAP, 8'hFF, 24'h808080);
    add_cfg(REG_PALETTE_SIZE, 24'd0);
    add_checked(24'hFFFFFF, 24'h000000, 8'd0, OUTCOME_MAPPED);
    add_cfg(REG_PALETTE_SIZE, 24'd4);
    add_cfg(REG_BACKGROUND_ENABLE, 24'd1);
    add_cfg(REG_BACKGROUND_COLOR, 24'h123456);
    add_cfg(REG_TRANSPARENT_ENABLE, 24'd1);
    add_cfg(REG_TRANSPARENT_COLOR, 24'h123456);
    add_cfg(REG_REPLACEMENT_COLOR, 24'hABCDEF);
    add_checked(24'h123456, 24'h123456, 8'd0, OUTCOME_BACKGROUND);
    add_cfg(REG_BACKGROUND_COLOR, 24'h654321);
    add_checked(24'h123456, 24'hABCDEF, 8'd0, OUTCOME_TRANSPARENT);
    add_checked(24'h654321, 24'h654321, 8'd0, OUTCOME_BACKGROUND);
    add_item(CMD_MAP, 8'h5A, 24'h00FF00);
    add_cfg(REG_BACKGROUND_ENABLE, 24'd0);
    add_cfg(REG_TRANSPARENT_ENABLE, 24'd0);
    add_item(CMD_MAP, 8'hA5, 24'h123456);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < directed_plan.size(); i++) begin
      row = directed_plan[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || directed_plan[i-1].kind != ROW_CFG) settle();
        write_reg(row.reg_sel, row.value);
      end else begin
        send_item(row.cmd, row.slot, row.value, row.kind == ROW_CHECKED, row.want);
      end
    end

    // fill the whole palette so any search range reads written entries
    for (int s = 0; s < DEPTH; s++) begin
      pix = (s == 0) ? 24'h000000 : (s == DEPTH - 1) ? 24'hFFFFFF :
            24'($urandom_range(0, 24'hFFFFFF));
      send_item(CMD_LOAD, s[7:0], pix, 1'b0, '0);
    end

    while (items_sent < 2000) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) size = 9'd0;
      else if (pick < 10) size = 9'd256;
      else if (pick < 15) size = 9'($urandom_range(257, 511));
      else if (pick < 22) size = 9'd1;
      else size = 9'($urandom_range(2, 16));
      settle();
      write_reg(REG_PALETTE_SIZE, {15'd0, size});
      write_reg(REG_BACKGROUND_ENABLE, 24'($urandom_range(0, 1)));
      bgc = pick_colour();
      write_reg(REG_BACKGROUND_COLOR, bgc);
      write_reg(REG_TRANSPARENT_ENABLE, 24'($urandom_range(0, 1)));
      write_reg(REG_TRANSPARENT_COLOR, ($urandom_range(0, 3) == 0) ? bgc : pick_colour());
      write_reg(REG_REPLACEMENT_COLOR, pick_colour());
      span = (size == 0) ? 1 : (size > DEPTH) ? DEPTH : size;

      n = $urandom_range(40, 80);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(CMD_LOAD, 8'($urandom_range(0, ($urandom_range(0, 1) != 0) ? span - 1 : 255)),
                    pick_colour(), 1'b0, '0);
        end else begin
          case ($urandom_range(0, 9))
            0: pix = cfg_bg_colour;
            1: pix = cfg_tr_colour;
            2: pix = palette_copy[$urandom_range(0, span - 1)];
            3: begin
              pix = palette_copy[$urandom_range(0, span - 1)];
              for (int c = 0; c < 3; c++) begin
                v = pix[c*8 +: 8] + $urandom_range(0, 6);
                v = (v < 3) ? 0 : (v > 258) ? 255 : v - 3;
                pix[c*8 +: 8] = v[7:0];
              end
            end
            4: pix = 24'h000000;
            5: pix = 24'hFFFFFF;
            default: pix = 24'($urandom_range(0, 24'hFFFFFF));
          endcase
          send_item(CMD_MAP, 8'($urandom_range(0, 255)), pix, 1'b0, '0);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_nearest_palette_color_mapper_unit: PASS");
    end else begin
      $display("tb_nearest_palette_color_mapper_unit: FAIL");
    end
    $finish;
  end

endmodule
